// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/vag_pkg.sv -----
package vag_pkg;

  localparam int CLIENT_COUNT = 32;
  localparam int IDX_W = $clog2(CLIENT_COUNT);
  localparam int ID_W = 5;
  localparam int VALUE_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_VOTE = 2'd0;
  localparam logic [1:0] KIND_OVERRIDE = 2'd1;
  localparam logic [1:0] KIND_RERUN = 2'd2;

  localparam logic [1:0] MODE_MIN = 2'd0;
  localparam logic [1:0] MODE_MAX = 2'd1;
  localparam logic [1:0] MODE_OR = 2'd2;
  localparam logic [1:0] MODE_AND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [ID_W-1:0] client_id;
    logic enable;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic notify;
    logic from_override;
    logic signed [VALUE_W-1:0] effective_value;
    logic winner_valid;
    logic [ID_W-1:0] winner_id;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [1:0] mode;
    logic [VALUE_W-1:0] fallback;
    logic [ID_W-1:0] client_id;
    logic enable;
    logic [VALUE_W-1:0] value;
  } elect_req_t;

  typedef struct packed {
    logic done;
    logic [VALUE_W-1:0] value;
    logic valid;
    logic [ID_W-1:0] winner;
  } elect_rsp_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ELECT,
    T_PUT
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_WRITE,
    E_SCAN,
    E_DRAIN,
    E_FINISH
  } elect_state_t;

endpackage

// ----- hw/rtl/vag_elect.sv -----
module vag_elect (
  input  logic                clk,
  input  logic                rst,
  input  vag_pkg::elect_req_t req,
  output vag_pkg::elect_rsp_t rsp
);

  vag_pkg::elect_state_t state, state_next;

  logic [1:0] mode;
  logic [vag_pkg::VALUE_W-1:0] dflt;
  logic [vag_pkg::IDX_W-1:0] wr_idx;
  logic [vag_pkg::ID_W-1:0] trigger;
  logic wr_flag;
  logic [vag_pkg::VALUE_W-1:0] wr_value;

  logic [vag_pkg::CLIENT_COUNT-1:0] enabled;
  logic [vag_pkg::VALUE_W-1:0] mem [vag_pkg::CLIENT_COUNT];

  logic [vag_pkg::IDX_W-1:0] addr;
  logic [vag_pkg::VALUE_W-1:0] rd_data;
  logic rd_flag;
  logic [vag_pkg::IDX_W-1:0] rd_idx;
  logic rd_vld;

  logic found;
  logic halted;
  logic [vag_pkg::VALUE_W-1:0] acc;
  logic [vag_pkg::ID_W-1:0] win;

  logic take;
  logic stop;
  logic step;
  logic last;

  always_comb begin
    take = 1'b1;
    stop = 1'b0;
    case (mode)
      vag_pkg::MODE_MIN: begin
        take = !found || ($signed(rd_data) < $signed(acc));
      end
      vag_pkg::MODE_MAX: begin
        take = !found || ($signed(acc) < $signed(rd_data));
      end
      vag_pkg::MODE_OR: begin
        stop = (rd_data != '0);
      end
      vag_pkg::MODE_AND: begin
        stop = (rd_data == '0);
      end
      default: begin
        take = 1'b1;
        stop = 1'b0;
      end
    endcase
  end

  assign step = rd_vld && rd_flag && !halted;
  assign last = (addr == vag_pkg::IDX_W'(vag_pkg::CLIENT_COUNT - 1));

  always_comb begin
    state_next = state;
    case (state)
      vag_pkg::E_IDLE: begin
        if (req.start) begin
          state_next = vag_pkg::E_WRITE;
        end
      end
      vag_pkg::E_WRITE: begin
        state_next = vag_pkg::E_SCAN;
      end
      vag_pkg::E_SCAN: begin
        if (last) begin
          state_next = vag_pkg::E_DRAIN;
        end
      end
      vag_pkg::E_DRAIN: begin
        state_next = vag_pkg::E_FINISH;
      end
      vag_pkg::E_FINISH: begin
        state_next = vag_pkg::E_IDLE;
      end
      default: begin
        state_next = vag_pkg::E_IDLE;
      end
    endcase
    rsp.done = (state == vag_pkg::E_FINISH);
    rsp.valid = found;
    rsp.value = found ? acc : dflt;
    rsp.winner = found ? win : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vag_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vag_pkg::E_WRITE) begin
      mem[wr_idx] <= wr_value;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (state == vag_pkg::E_IDLE && req.start) begin
      mode <= req.mode;
      dflt <= req.fallback;
      wr_idx <= vag_pkg::IDX_W'(req.client_id);
      trigger <= req.client_id;
      wr_flag <= req.enable;
      wr_value <= req.value;
    end
    if (state == vag_pkg::E_WRITE) begin
      addr <= '0;
    end else if (state == vag_pkg::E_SCAN) begin
      addr <= addr + vag_pkg::IDX_W'(1);
    end
    rd_flag <= enabled[addr];
    rd_idx <= addr;
    if (step && take) begin
      acc <= rd_data;
      if (mode == vag_pkg::MODE_MIN || mode == vag_pkg::MODE_MAX) begin
        win <= vag_pkg::ID_W'(rd_idx);
      end else begin
        win <= trigger;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
      rd_vld <= 1'b0;
      found <= 1'b0;
      halted <= 1'b0;
    end else begin
      rd_vld <= (state == vag_pkg::E_SCAN);
      if (state == vag_pkg::E_WRITE) begin
        enabled[wr_idx] <= wr_flag;
        found <= 1'b0;
        halted <= 1'b0;
      end else if (step) begin
        if (take) begin
          found <= 1'b1;
        end
        if (stop) begin
          halted <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/vote_aggregator_unit.sv -----
// A vote request runs one election pass that reads one table entry per cycle.
// Its result is loaded in T_PUT after the pass has written the entry, scanned the
// table, drained and finished; the input is ready again in the cycle after the load.
// Override, rerun and unused-kind requests go straight to T_PUT to load their result,
// and no request is taken before that; a stalled result holds the next request back.
// Synchronous reset clears the vote table flags, election state, override, config and output-valid registers.
module vote_aggregator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  vag_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output vag_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vag_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vag_pkg::VALUE_W-1:0]          cfg_data
);

  vag_pkg::top_state_t state, state_next;

  logic [1:0] vote_mode;
  logic [vag_pkg::VALUE_W-1:0] fallback_value;
  logic ever_voted;
  logic [vag_pkg::VALUE_W-1:0] elected_value;
  logic elected_valid;
  logic [vag_pkg::ID_W-1:0] elected_winner;
  logic override_active;
  logic [vag_pkg::VALUE_W-1:0] override_value;
  logic [vag_pkg::ID_W-1:0] override_source;
  logic pend_notify;

  logic accept;
  logic is_vote;
  logic put;
  logic changed;
  vag_pkg::elect_req_t req;
  vag_pkg::elect_rsp_t rsp;
  vag_pkg::out_item_t report;

  vag_elect u_elect (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    in_ready = (state == vag_pkg::T_IDLE);
    accept = in_valid && in_ready;
    is_vote = (in_data.kind == vag_pkg::KIND_VOTE) &&
              (32'(in_data.client_id) < 32'(vag_pkg::CLIENT_COUNT));
    put = (state == vag_pkg::T_PUT) && (!out_valid || out_ready);
    changed = !ever_voted || (rsp.value != elected_value) ||
              (rsp.valid != elected_valid) ||
              (rsp.valid && (rsp.winner != elected_winner));

    req.start = accept && is_vote;
    req.mode = vote_mode;
    req.fallback = fallback_value;
    req.client_id = in_data.client_id;
    req.enable = in_data.enable;
    req.value = in_data.value;

    state_next = state;
    case (state)
      vag_pkg::T_IDLE: begin
        if (accept) begin
          state_next = is_vote ? vag_pkg::T_ELECT : vag_pkg::T_PUT;
        end
      end
      vag_pkg::T_ELECT: begin
        if (rsp.done) begin
          state_next = vag_pkg::T_PUT;
        end
      end
      vag_pkg::T_PUT: begin
        if (put) begin
          state_next = vag_pkg::T_IDLE;
        end
      end
      default: begin
        state_next = vag_pkg::T_IDLE;
      end
    endcase

    report.notify = pend_notify;
    if (override_active) begin
      report.from_override = 1'b1;
      report.effective_value = override_value;
      report.winner_valid = 1'b1;
      report.winner_id = override_source;
    end else if (ever_voted) begin
      report.from_override = 1'b0;
      report.effective_value = elected_value;
      report.winner_valid = elected_valid;
      report.winner_id = elected_valid ? elected_winner : '0;
    end else begin
      report.from_override = 1'b0;
      report.effective_value = (vote_mode == vag_pkg::MODE_OR) ? '0 : fallback_value;
      report.winner_valid = 1'b0;
      report.winner_id = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vag_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_data <= report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_mode <= '0;
      fallback_value <= '0;
      ever_voted <= 1'b0;
      elected_value <= '0;
      elected_valid <= 1'b0;
      elected_winner <= '0;
      override_active <= 1'b0;
      override_value <= '0;
      override_source <= '0;
      pend_notify <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vag_pkg::CFG_VOTE_MODE: begin
            vote_mode <= cfg_data[1:0];
          end
          vag_pkg::CFG_DEFAULT_VALUE: begin
            fallback_value <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        pend_notify <= (in_data.kind == vag_pkg::KIND_OVERRIDE) ||
                       (in_data.kind == vag_pkg::KIND_RERUN);
        if (in_data.kind == vag_pkg::KIND_OVERRIDE) begin
          override_active <= in_data.enable;
          if (in_data.enable) begin
            override_value <= in_data.value;
            override_source <= in_data.client_id;
          end
        end
      end
      if (state == vag_pkg::T_ELECT && rsp.done) begin
        pend_notify <= changed && !override_active;
        elected_value <= rsp.value;
        elected_valid <= rsp.valid;
        elected_winner <= rsp.winner;
        ever_voted <= 1'b1;
      end
      if (put) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/vag_checker.sv -----
`include "assert_macros.svh"

module vag_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input vag_pkg::out_item_t            out_data
);

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "Result valid right after reset.")
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "Stalled.")
  `ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "Accepted while busy.")
  `ASSERT_CLK(a_override_winner, out_valid && out_data.from_override |-> out_data.winner_valid, "No winner.")
  `ASSERT_CLK(a_no_winner_id, out_valid && !out_data.winner_valid |-> out_data.winner_id == '0, "Stray id.")

endmodule

bind vote_aggregator_unit vag_checker u_vag_checker (.*);
